// ----- hdl/dual_pedal_debounce_qualifier_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the dual pedal debounce qualifier
// Shared concurrent check forms, sampled on the rising clock edge.
// ---------------------------------------------------------------------------
`ifndef DUAL_PEDAL_DEBOUNCE_QUALIFIER_MACROS_SVH
`define DUAL_PEDAL_DEBOUNCE_QUALIFIER_MACROS_SVH

// same-cycle implication, off while reset is high
`define DPDQ_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("dpdq check failed");

// next-cycle implication, off while reset is high
`define DPDQ_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("dpdq check failed");

`endif

// ----- hdl/dpdq_pkg.sv -----
// ---------------------------------------------------------------------------
// Dual pedal debounce qualifier package
// Shared codes, widths, reset values and word types.
// ---------------------------------------------------------------------------
package dpdq_pkg;

   localparam int SAMPLE_COUNT_DEFAULT = 5;
   localparam int TIME_WIDTH           = 32;
   localparam int DEBOUNCE_WIDTH       = 16;
   localparam int NOISE_WIDTH          = 8;
   localparam int CSR_INDEX_WIDTH      = 2;
   localparam int CSR_DATA_WIDTH       = 16;
   localparam int QUEUE_DEPTH          = 4;
   localparam int QUEUE_COUNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);
   localparam int QUEUE_INDEX_WIDTH    = $clog2(QUEUE_DEPTH);

   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET = DEBOUNCE_WIDTH'(50);
   localparam logic [NOISE_WIDTH-1:0]    NOISE_RESET    = NOISE_WIDTH'(10);

   localparam logic KIND_EDGE   = 1'b0;
   localparam logic KIND_UPDATE = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SINGLE_MODE  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_MS  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NOISE_WINDOW = 2'd2;

   typedef struct packed {
      logic hit;
      logic pressed;
   } lane_result_type;

   typedef struct packed {
      logic pedal_id;
      logic pressed;
      logic last;
   } rsp_word_type;

endpackage

// ----- hdl/dpdq_lane.sv -----
// ---------------------------------------------------------------------------
// Pedal lane
// Pending mark, stable level and time stamps of one pedal; qualifies a
// service pass against the noise window, sample agreement, level change
// and debounce time.
// ---------------------------------------------------------------------------
module dpdq_lane #(
   parameter int SAMPLE_COUNT = dpdq_pkg::SAMPLE_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                mark,
   input  logic                                service,
   input  logic [dpdq_pkg::TIME_WIDTH-1:0]     now_ms,
   input  logic [SAMPLE_COUNT-1:0]             samples,
   input  logic [dpdq_pkg::DEBOUNCE_WIDTH-1:0] debounce_ms,
   input  logic [dpdq_pkg::NOISE_WIDTH-1:0]    noise_window_ms,
   output dpdq_pkg::lane_result_type           result
);
   import dpdq_pkg::*;

   logic                  pending_ff, pending_in;
   logic                  stable_ff, stable_in;
   logic [TIME_WIDTH-1:0] change_time_ff, change_time_in;
   logic [TIME_WIDTH-1:0] service_time_ff, service_time_in;

   logic                  serve;
   logic                  noise_hit;
   logic                  agree;
   logic                  level;
   logic                  bounce_hit;
   logic                  take_change;
   logic [TIME_WIDTH-1:0] since_service;
   logic [TIME_WIDTH-1:0] since_change;

   always_comb begin
      serve         = service && pending_ff;
      since_service = now_ms - service_time_ff;
      since_change  = now_ms - change_time_ff;
      noise_hit     = (service_time_ff != '0) &&
                      (since_service < TIME_WIDTH'(noise_window_ms));
      agree         = (samples == '0) || (samples == '1);
      level         = |samples;
      bounce_hit    = since_change < TIME_WIDTH'(debounce_ms);
      take_change   = serve && !noise_hit && agree && (level != stable_ff) && !bounce_hit;

      pending_in      = pending_ff;
      stable_in       = stable_ff;
      change_time_in  = change_time_ff;
      service_time_in = service_time_ff;
      if (mark) begin
         pending_in = 1'b1;
      end else if (serve) begin
         pending_in = 1'b0;
      end
      if (serve && !noise_hit) begin
         service_time_in = now_ms;
      end
      if (take_change) begin
         stable_in      = level;
         change_time_in = now_ms;
      end

      result.hit     = take_change;
      result.pressed = !level;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff      <= 1'b0;
         stable_ff       <= 1'b1;
         change_time_ff  <= '0;
         service_time_ff <= '0;
      end else begin
         pending_ff      <= pending_in;
         stable_ff       <= stable_in;
         change_time_ff  <= change_time_in;
         service_time_ff <= service_time_in;
      end
   end

endmodule

// ----- hdl/dpdq_merge.sv -----
// ---------------------------------------------------------------------------
// Result merge queue
// Orders the lane results (pedal 1 first), marks the final word of an
// update and holds them in a short shift queue toward the result port.
// ---------------------------------------------------------------------------
module dpdq_merge (
   input  logic                      clock,
   input  logic                      reset,
   input  dpdq_pkg::lane_result_type lane_first,
   input  dpdq_pkg::lane_result_type lane_second,
   output logic                      full,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output dpdq_pkg::rsp_word_type    rsp_word
);
   import dpdq_pkg::*;

   rsp_word_type                 queue_ff [QUEUE_DEPTH];
   rsp_word_type                 queue_in [QUEUE_DEPTH];
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;
   logic [QUEUE_COUNT_WIDTH-1:0] base;
   logic                         pop;
   logic [1:0]                   n_push;
   rsp_word_type                 word_a, word_b, word_first;

   always_comb begin
      word_a     = '{pedal_id: 1'b0, pressed: lane_first.pressed, last: !lane_second.hit};
      word_b     = '{pedal_id: 1'b1, pressed: lane_second.pressed, last: 1'b1};
      word_first = lane_first.hit ? word_a : word_b;
      n_push     = 2'(lane_first.hit) + 2'(lane_second.hit);
      pop        = (count_ff != '0) && !rsp_stall;
      base       = count_ff - QUEUE_COUNT_WIDTH'(pop);

      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (pop && (i < QUEUE_DEPTH - 1)) begin
            queue_in[i] = queue_ff[i+1];
         end else begin
            queue_in[i] = queue_ff[i];
         end
         if ((n_push != 2'd0) && (QUEUE_COUNT_WIDTH'(i) == base)) begin
            queue_in[i] = word_first;
         end
         if ((n_push == 2'd2) && (QUEUE_COUNT_WIDTH'(i) == base + 1'b1)) begin
            queue_in[i] = word_b;
         end
      end
      count_in = base + QUEUE_COUNT_WIDTH'(n_push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      queue_ff <= queue_in;
   end

   assign full      = count_ff > QUEUE_COUNT_WIDTH'(QUEUE_DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign rsp_word  = queue_ff[0];

endmodule

// ----- hdl/dual_pedal_debounce_qualifier.sv -----
// ---------------------------------------------------------------------------
// Dual pedal debounce qualifier
// Qualifies one or two active-low pedal switches into press/release words.
// ---------------------------------------------------------------------------
// An edge word marks a pedal pending; an update word carries the time and
// the pin samples and serves pedal 1, then pedal 2 in dual mode, each in its
// own lane in the cycle the word is taken. A word is taken every cycle while
// the four-entry result queue has room for two results; each result leaves
// on the rsp_ port one per cycle while rsp_stall is low. Results appear in
// the cycle after their update word at the earliest.
module dual_pedal_debounce_qualifier #(
   parameter int SAMPLE_COUNT = dpdq_pkg::SAMPLE_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [dpdq_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dpdq_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic                                req_pedal_sel,
   input  logic [dpdq_pkg::TIME_WIDTH-1:0]     req_now_ms,
   input  logic [SAMPLE_COUNT-1:0]             req_samples_first,
   input  logic [SAMPLE_COUNT-1:0]             req_samples_second,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_pedal_id,
   output logic                                rsp_pressed,
   output logic                                rsp_last
);
   import dpdq_pkg::*;
`include "dual_pedal_debounce_qualifier_macros.svh"

   logic                      single_mode_ff;
   logic [DEBOUNCE_WIDTH-1:0] debounce_ms_ff;
   logic [NOISE_WIDTH-1:0]    noise_window_ff;

   logic            take;
   logic            queue_full;
   lane_result_type lane_first, lane_second;
   rsp_word_type    rsp_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         single_mode_ff  <= 1'b0;
         debounce_ms_ff  <= DEBOUNCE_RESET;
         noise_window_ff <= NOISE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SINGLE_MODE:  single_mode_ff  <= csr_wdata[0];
            CSR_DEBOUNCE_MS:  debounce_ms_ff  <= csr_wdata[DEBOUNCE_WIDTH-1:0];
            CSR_NOISE_WINDOW: noise_window_ff <= csr_wdata[NOISE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall = queue_full;
   assign take      = req_valid && !req_stall;

   dpdq_lane #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_lane_first (
      .clock           (clock),
      .reset           (reset),
      .mark            (take && (req_kind == KIND_EDGE) && !req_pedal_sel),
      .service         (take && (req_kind == KIND_UPDATE)),
      .now_ms          (req_now_ms),
      .samples         (req_samples_first),
      .debounce_ms     (debounce_ms_ff),
      .noise_window_ms (noise_window_ff),
      .result          (lane_first)
   );

   dpdq_lane #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_lane_second (
      .clock           (clock),
      .reset           (reset),
      .mark            (take && (req_kind == KIND_EDGE) && req_pedal_sel),
      .service         (take && (req_kind == KIND_UPDATE) && !single_mode_ff),
      .now_ms          (req_now_ms),
      .samples         (req_samples_second),
      .debounce_ms     (debounce_ms_ff),
      .noise_window_ms (noise_window_ff),
      .result          (lane_second)
   );

   dpdq_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .lane_first  (lane_first),
      .lane_second (lane_second),
      .full        (queue_full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word)
   );

   assign rsp_pedal_id = rsp_word.pedal_id;
   assign rsp_pressed  = rsp_word.pressed;
   assign rsp_last     = rsp_word.last;

   `DPDQ_ASSERT_NOW(a_second_lane_dual_only, clock, reset, lane_second.hit, !single_mode_ff)
   `DPDQ_ASSERT_NOW(a_hit_on_update_only, clock, reset, lane_first.hit || lane_second.hit, take && (req_kind == KIND_UPDATE))
   `DPDQ_ASSERT_NOW(a_second_pedal_is_last, clock, reset, rsp_valid && rsp_pedal_id, rsp_last)
   `DPDQ_ASSERT_NEXT(a_hit_reaches_queue, clock, reset, lane_first.hit || lane_second.hit, rsp_valid)

endmodule
